// ----- design/rptw_pkg.sv -----
`timescale 1ns / 1ps

package rptw_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned FRAMES_DEF = 64;
  localparam int unsigned LEVELS_DEF = 5;

  // Fixed geometry of a table entry and of the command fields.
  localparam int unsigned INDEX_BITS = 9;
  localparam int unsigned ENTRY_W    = 64;
  localparam int unsigned PAGE_W     = 52;
  localparam int unsigned PAGE_LSB   = 12;
  localparam int unsigned VPN_W      = 45;
  localparam int unsigned ROOT_W     = 6;
  localparam int unsigned FFREE_W    = 7;
  localparam int unsigned CFG_AW     = 3;
  localparam int unsigned CFG_DW     = 32;

  typedef enum logic [1:0] {
    CMD_QUERY = 2'd0,
    CMD_MAP   = 2'd1,
    CMD_UNMAP = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Register index as seen in bit 2 of the byte address.
  typedef enum logic {
    REG_ROOT_FRAME = 1'b0,
    REG_FIRST_FREE = 1'b1
  } reg_e;

  // Microprogram addresses.
  typedef enum logic [3:0] {
    ST_CLEAR   = 4'd0,
    ST_IDLE    = 4'd1,
    ST_CHK     = 4'd2,
    ST_RD      = 4'd3,
    ST_EVAL    = 4'd4,
    ST_DISP    = 4'd5,
    ST_LEAFCHK = 4'd6,
    ST_LRD     = 4'd7,
    ST_LEVAL   = 4'd8,
    ST_MAPCHK  = 4'd9,
    ST_ALLOC   = 4'd10,
    ST_AWR     = 4'd11,
    ST_LWR     = 4'd12,
    ST_FAIL    = 4'd13,
    ST_DONE    = 4'd14
  } step_e;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_NO_START  = 4'd2,
    C_CLR_MORE  = 4'd3,
    C_WALK_DONE = 4'd4,
    C_ENTRY_OK  = 4'd5,
    C_IS_MAP    = 4'd6,
    C_LEAF_MISS = 4'd7,
    C_MAP_FAIL  = 4'd8,
    C_AT_LEAF   = 4'd9
  } cond_e;

  // Datapath actions.
  typedef enum logic [3:0] {
    ACT_NONE    = 4'd0,
    ACT_CLEAR   = 4'd1,
    ACT_LOAD    = 4'd2,
    ACT_EVAL    = 4'd3,
    ACT_LEAF    = 4'd4,
    ACT_ALLOC   = 4'd5,
    ACT_WR_LEAF = 4'd6,
    ACT_FAIL    = 4'd7,
    ACT_EMIT    = 4'd8
  } act_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_e target;
  } uword_t;

  // Status flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic start;
    logic clr_more;
    logic walk_done;
    logic entry_ok;
    logic is_map;
    logic leaf_miss;
    logic map_fail;
    logic at_leaf;
  } flags_t;

endpackage

// ----- design/radix_page_table_walker_unit.sv -----
`timescale 1ns / 1ps

// Radix page-table walker over an internal frame memory of FRAMES tables of
// 512 entries of 64 bits each. A command (query, map or unmap) is taken as a
// transfer at a clock edge where start is high and busy is low; busy then
// stays high until the command is finished. Each command produces exactly
// one result, shown on phys_page_o, found_o and status_o for the single cycle
// in which done_o is high. The receiver cannot stall, so no result waits.
// Control is a microprogram: a step counter indexes a small control store
// whose word selects one datapath action and one conditional jump.
// Each interior level of a walk runs a check, a read and an evaluate step
// around the registered read of the frame memory, and a map runs an
// allocation check and an entry write per allocated table. One command is in
// flight at a time; the next can be taken at the end of the cycle after the
// done strobe. After reset the block sweeps all FRAMES*512 entries of the
// frame memory to zero, one entry a cycle, with busy held high.
// The two registers sit on an APB-style port at byte addresses 0 (root
// frame) and 4 (first free frame); pready is always high and writes are
// expected only while the block is idle.
module radix_page_table_walker_unit #(
  parameter int unsigned FRAMES = rptw_pkg::FRAMES_DEF,
  parameter int unsigned LEVELS = rptw_pkg::LEVELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd_i,
  input  logic [rptw_pkg::VPN_W-1:0]    virt_page_i,
  input  logic [rptw_pkg::PAGE_W-1:0]   new_phys_page_i,
  output logic                          done_o,
  output logic [rptw_pkg::PAGE_W-1:0]   phys_page_o,
  output logic                          found_o,
  output logic                          status_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rptw_pkg::CFG_AW-1:0]   paddr,
  input  logic [rptw_pkg::CFG_DW-1:0]   pwdata,
  output logic [rptw_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import rptw_pkg::*;

  localparam int unsigned FB    = $clog2(FRAMES);
  localparam int unsigned AW    = FB + INDEX_BITS;
  localparam int unsigned DEPTH = FRAMES << INDEX_BITS;
  localparam int unsigned LW    = $clog2(LEVELS);
  localparam int unsigned VW    = LEVELS * INDEX_BITS;
  localparam int unsigned NW    = $clog2(FRAMES + (1 << FFREE_W) + LEVELS) + 1;

  // Configuration and allocator state.
  logic [ROOT_W-1:0]  root_q;
  logic [FFREE_W-1:0] ffree_q;
  logic [NW-1:0]      alloc_q;
  logic [AW-1:0]      clr_q;

  // Command and walk state.
  cmd_e               cmd_q;
  logic [VW-1:0]      vp_q;
  logic [PAGE_W-1:0]  ppn_q;
  logic [FB-1:0]      tbl_q;
  logic [LW-1:0]      lvl_q;
  logic               bad_q;

  // Result registers.
  logic [PAGE_W-1:0]  phys_q;
  logic               found_q;
  logic               status_q;

  // Frame memory.
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic [ENTRY_W-1:0] wdata;
  logic [AW-1:0]      maddr;
  logic               we;

  uword_t             uw;
  flags_t             flags;
  logic               accept;
  logic               cfg_wr;
  logic [INDEX_BITS-1:0] idx;
  logic [NW-1:0]      root_ext;
  logic [NW-1:0]      next_w;
  logic [NW-1:0]      need_w;
  logic [FB-1:0]      nf;
  logic               at_leaf;
  logic               nxt_big;

  rptw_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uw),
    .busy_o  (busy)
  );

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_ROOT_FRAME: prdata = CFG_DW'(root_q);
      REG_FIRST_FREE: prdata = CFG_DW'(ffree_q);
      default:        prdata = '0;
    endcase
  end

  // Index of the current level, most significant level first.
  always_comb begin
    idx = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (lvl_q == LW'(l)) begin
        idx = vp_q[INDEX_BITS*(LEVELS-1-l) +: INDEX_BITS];
      end
    end
  end

  assign root_ext = NW'(root_q);
  assign next_w   = NW'(ffree_q) + alloc_q;
  assign need_w   = NW'(LEVELS - 1) - NW'(lvl_q);
  assign nf       = next_w[FB-1:0];
  assign at_leaf  = (lvl_q == LW'(LEVELS - 1));
  assign nxt_big  = (rdata_q[ENTRY_W-1:PAGE_LSB] >= PAGE_W'(FRAMES));

  always_comb begin
    flags.start     = start;
    flags.clr_more  = (clr_q != AW'(DEPTH - 1));
    flags.walk_done = bad_q || at_leaf;
    flags.entry_ok  = rdata_q[0] && !nxt_big;
    flags.is_map    = (cmd_q == CMD_MAP);
    flags.leaf_miss = bad_q || !at_leaf || (cmd_q == CMD_NOP);
    flags.map_fail  = bad_q || (!at_leaf && ((next_w + need_w) > NW'(FRAMES)));
    flags.at_leaf   = at_leaf;
  end

  // One shared address for the read and the write of each step.
  assign maddr = (uw.act == ACT_CLEAR) ? clr_q : {tbl_q, idx};

  always_comb begin
    we    = 1'b0;
    wdata = '0;
    unique case (uw.act)
      ACT_CLEAR: begin
        we = 1'b1;
      end
      ACT_ALLOC: begin
        we    = 1'b1;
        wdata = {{(PAGE_W-FB){1'b0}}, nf, {(PAGE_LSB-1){1'b0}}, 1'b1};
      end
      ACT_WR_LEAF: begin
        we    = 1'b1;
        wdata = {ppn_q, {(PAGE_LSB-1){1'b0}}, 1'b1};
      end
      ACT_LEAF: begin
        // An unmap rewrites the leaf it just read with the valid bit cleared.
        we    = (cmd_q == CMD_UNMAP);
        wdata = {rdata_q[ENTRY_W-1:1], 1'b0};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[maddr] <= wdata;
    end
    rdata_q <= mem[maddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q   <= '0;
      ffree_q  <= FFREE_W'(1);
      alloc_q  <= '0;
      clr_q    <= '0;
      cmd_q    <= CMD_NOP;
      vp_q     <= '0;
      ppn_q    <= '0;
      tbl_q    <= '0;
      lvl_q    <= '0;
      bad_q    <= 1'b0;
      phys_q   <= '0;
      found_q  <= 1'b0;
      status_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_e'(paddr[2]))
          REG_ROOT_FRAME: root_q  <= pwdata[ROOT_W-1:0];
          REG_FIRST_FREE: ffree_q <= pwdata[FFREE_W-1:0];
          default:        root_q  <= root_q;
        endcase
      end
      unique case (uw.act)
        ACT_CLEAR: begin
          clr_q <= clr_q + AW'(1);
        end
        ACT_LOAD: begin
          if (accept) begin
            cmd_q    <= cmd_e'(cmd_i);
            vp_q     <= virt_page_i[VW-1:0];
            ppn_q    <= new_phys_page_i;
            tbl_q    <= root_ext[FB-1:0];
            lvl_q    <= '0;
            bad_q    <= (root_ext >= NW'(FRAMES));
            phys_q   <= '0;
            found_q  <= 1'b0;
            status_q <= 1'b0;
          end
        end
        ACT_EVAL: begin
          // Follow a valid interior entry; a frame beyond the memory ends
          // the walk as a fault.
          if (rdata_q[0]) begin
            if (nxt_big) begin
              bad_q <= 1'b1;
            end else begin
              tbl_q <= rdata_q[PAGE_LSB +: FB];
              lvl_q <= lvl_q + LW'(1);
            end
          end
        end
        ACT_LEAF: begin
          if ((cmd_q == CMD_QUERY) && rdata_q[0]) begin
            phys_q  <= rdata_q[ENTRY_W-1:PAGE_LSB];
            found_q <= 1'b1;
          end
        end
        ACT_ALLOC: begin
          tbl_q   <= nf;
          lvl_q   <= lvl_q + LW'(1);
          alloc_q <= alloc_q + NW'(1);
        end
        ACT_FAIL: begin
          status_q <= 1'b1;
        end
        default: begin
          bad_q <= bad_q;
        end
      endcase
    end
  end

  assign done_o      = (uw.act == ACT_EMIT);
  assign phys_page_o = phys_q;
  assign found_o     = found_q;
  assign status_o    = status_q;

endmodule

// ----- design/rptw_seq.sv -----
`timescale 1ns / 1ps

module rptw_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rptw_pkg::flags_t flags_i,
  output rptw_pkg::uword_t uword_o,
  output logic             busy_o
);
  import rptw_pkg::*;

  step_e  step_q, step_d;
  uword_t uw;
  logic   take;

  // Control store: one word per step. A step jumps to its target when its
  // condition holds and falls through to the next step otherwise.
  always_comb begin
    unique case (step_q)
      ST_CLEAR:   uw = '{act: ACT_CLEAR,   cond: C_CLR_MORE,  target: ST_CLEAR};
      ST_IDLE:    uw = '{act: ACT_LOAD,    cond: C_NO_START,  target: ST_IDLE};
      ST_CHK:     uw = '{act: ACT_NONE,    cond: C_WALK_DONE, target: ST_DISP};
      ST_RD:      uw = '{act: ACT_NONE,    cond: C_NEVER,     target: ST_EVAL};
      ST_EVAL:    uw = '{act: ACT_EVAL,    cond: C_ENTRY_OK,  target: ST_CHK};
      ST_DISP:    uw = '{act: ACT_NONE,    cond: C_IS_MAP,    target: ST_MAPCHK};
      ST_LEAFCHK: uw = '{act: ACT_NONE,    cond: C_LEAF_MISS, target: ST_DONE};
      ST_LRD:     uw = '{act: ACT_NONE,    cond: C_NEVER,     target: ST_LEVAL};
      ST_LEVAL:   uw = '{act: ACT_LEAF,    cond: C_ALWAYS,    target: ST_DONE};
      ST_MAPCHK:  uw = '{act: ACT_NONE,    cond: C_MAP_FAIL,  target: ST_FAIL};
      ST_ALLOC:   uw = '{act: ACT_NONE,    cond: C_AT_LEAF,   target: ST_LWR};
      ST_AWR:     uw = '{act: ACT_ALLOC,   cond: C_ALWAYS,    target: ST_ALLOC};
      ST_LWR:     uw = '{act: ACT_WR_LEAF, cond: C_ALWAYS,    target: ST_DONE};
      ST_FAIL:    uw = '{act: ACT_FAIL,    cond: C_NEVER,     target: ST_DONE};
      ST_DONE:    uw = '{act: ACT_EMIT,    cond: C_ALWAYS,    target: ST_IDLE};
      default:    uw = '{act: ACT_NONE,    cond: C_ALWAYS,    target: ST_IDLE};
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_START:  take = !flags_i.start;
      C_CLR_MORE:  take = flags_i.clr_more;
      C_WALK_DONE: take = flags_i.walk_done;
      C_ENTRY_OK:  take = flags_i.entry_ok;
      C_IS_MAP:    take = flags_i.is_map;
      C_LEAF_MISS: take = flags_i.leaf_miss;
      C_MAP_FAIL:  take = flags_i.map_fail;
      C_AT_LEAF:   take = flags_i.at_leaf;
      default:     take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      step_d = uw.target;
    end else begin
      step_d = step_e'(4'(step_q) + 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_CLEAR;
    end else begin
      step_q <= step_d;
    end
  end

  assign uword_o = uw;
  assign busy_o  = (step_q != ST_IDLE);

endmodule
